// ===== design/frsq_pkg.sv =====
// Shared types, constants and single-precision helper functions for the rsqrt pipeline.
package frsq_pkg;

    localparam int NEWTON_STEPS = 3;
    localparam int MUL_LAT      = 4;
    localparam int ADD_LAT      = 6;
    localparam int TOTAL_LAT    = MUL_LAT + NEWTON_STEPS * (3 * MUL_LAT + ADD_LAT);

    localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
    localparam logic [31:0] F_HALF      = 32'h3F000000;
    localparam logic [31:0] F_THREEHALF = 32'h3FC00000;
    localparam logic [31:0] F_QNAN      = 32'h7FC00000;
    localparam logic [31:0] F_INF       = 32'h7F800000;
    localparam logic [31:0] SIGN_BIT    = 32'h80000000;

    // Values riding alongside an item: half operand and current estimate.
    typedef struct packed {
        logic [31:0] h;
        logic [31:0] y;
    } t_side;

    typedef struct packed {
        logic [23:0]        m;
        logic signed [10:0] e;
    } t_unp;

    typedef struct packed {
        logic [47:0]        sig;
        logic signed [10:0] e;
    } t_norm;

    function automatic logic is_nan(logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(logic [31:0] b);
        return b[30:0] == F_INF[30:0];
    endfunction

    function automatic logic is_zero(logic [31:0] b);
        return b[30:0] == 31'd0;
    endfunction

    // Significand in [2^23, 2^24) plus effective biased exponent.
    function automatic t_unp fp_unpack(logic [31:0] b);
        t_unp       u;
        logic [4:0] lz;
        lz = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (b[i]) begin
                lz = 5'(23 - i);
            end
        end
        if (b[30:23] == 8'd0) begin
            u.m = {1'b0, b[22:0]} << lz;
            u.e = 11'sd1 - $signed({6'd0, lz});
        end else begin
            u.m = {1'b1, b[22:0]};
            u.e = $signed({3'd0, b[30:23]});
        end
        return u;
    endfunction

    // Shift into the subnormal range with sticky when the exponent is below one.
    function automatic t_norm fp_denorm(logic signed [10:0] e, logic [47:0] sig);
        t_norm       n;
        logic [10:0] sh;
        logic [47:0] msk;
        n.sig = sig;
        n.e   = e;
        sh    = 11'(11'sd1 - e);
        msk   = ~(48'hFFFF_FFFF_FFFF << sh[5:0]);
        if (e < 11'sd1) begin
            if (sh >= 11'd48) begin
                n.sig = 48'd1;
            end else begin
                n.sig = (sig >> sh[5:0]) | {47'd0, |(sig & msk)};
            end
            n.e = 11'sd1;
        end
        return n;
    endfunction

    // Round to nearest even and pack; sig carries 24 result bits over 24 guard bits.
    function automatic logic [31:0] fp_round(logic s, logic signed [10:0] e, logic [47:0] sig);
        logic [24:0]        mr;
        logic [23:0]        rem;
        logic signed [10:0] em1;
        logic [32:0]        bits;
        mr  = {1'b0, sig[47:24]};
        rem = sig[23:0];
        if (rem > 24'h800000 || (rem == 24'h800000 && sig[24])) begin
            mr = mr + 25'd1;
        end
        em1  = e - 11'sd1;
        bits = {2'd0, em1[7:0], 23'd0} + {8'd0, mr};
        if (bits >= {1'b0, F_INF}) begin
            return {s, F_INF[30:0]};
        end
        return {s, bits[30:0]};
    endfunction

endpackage

// ===== design/frsq_fmul.sv =====
// Four-stage single-precision multiplier with a sideband that travels with each item.
module frsq_fmul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    input  frsq_pkg::t_side      i_side,
    output logic                 o_valid,
    output logic [31:0]          o_res,
    output frsq_pkg::t_side      o_side
);

    logic [3:1] r_v;

    // stage 1: specials, unpack
    logic               r1_spc;
    logic [31:0]        r1_sval;
    logic               r1_s;
    frsq_pkg::t_unp     r1_ua, r1_ub;
    frsq_pkg::t_side    r1_side;
    // stage 2: product
    logic               r2_spc;
    logic [31:0]        r2_sval;
    logic               r2_s;
    logic [47:0]        r2_prod;
    logic signed [10:0] r2_e;
    frsq_pkg::t_side    r2_side;
    // stage 3: normalize, denormalize
    logic               r3_spc;
    logic [31:0]        r3_sval;
    logic               r3_s;
    logic               r3_ovf;
    frsq_pkg::t_norm    r3_n;
    frsq_pkg::t_side    r3_side;

    logic               n_s;
    logic               n_spc;
    logic [31:0]        n_sval;
    logic [47:0]        n_sig;
    logic signed [10:0] n_e;

    always_comb begin
        n_s    = i_a[31] ^ i_b[31];
        n_spc  = 1'b1;
        n_sval = frsq_pkg::F_QNAN;
        if (frsq_pkg::is_nan(i_a) || frsq_pkg::is_nan(i_b)) begin
            n_sval = frsq_pkg::F_QNAN;
        end else if (frsq_pkg::is_inf(i_a) || frsq_pkg::is_inf(i_b)) begin
            if (frsq_pkg::is_zero(i_a) || frsq_pkg::is_zero(i_b)) begin
                n_sval = frsq_pkg::F_QNAN;
            end else begin
                n_sval = {n_s, frsq_pkg::F_INF[30:0]};
            end
        end else if (frsq_pkg::is_zero(i_a) || frsq_pkg::is_zero(i_b)) begin
            n_sval = {n_s, 31'd0};
        end else begin
            n_spc = 1'b0;
        end
    end

    always_comb begin
        n_sig = r2_prod;
        n_e   = r2_e;
        if (!r2_prod[47]) begin
            n_sig = {r2_prod[46:0], 1'b0};
            n_e   = r2_e - 11'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else begin
            r_v     <= {r_v[2:1], i_valid};
            o_valid <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_spc  <= n_spc;
        r1_sval <= n_sval;
        r1_s    <= n_s;
        r1_ua   <= frsq_pkg::fp_unpack(i_a);
        r1_ub   <= frsq_pkg::fp_unpack(i_b);
        r1_side <= i_side;

        r2_spc  <= r1_spc;
        r2_sval <= r1_sval;
        r2_s    <= r1_s;
        r2_prod <= 48'(r1_ua.m) * 48'(r1_ub.m);
        r2_e    <= r1_ua.e + r1_ub.e - 11'sd126;
        r2_side <= r1_side;

        r3_spc  <= r2_spc;
        r3_sval <= r2_sval;
        r3_s    <= r2_s;
        r3_ovf  <= n_e >= 11'sd255;
        r3_n    <= frsq_pkg::fp_denorm(n_e, n_sig);
        r3_side <= r2_side;

        if (r3_spc) begin
            o_res <= r3_sval;
        end else if (r3_ovf) begin
            o_res <= {r3_s, frsq_pkg::F_INF[30:0]};
        end else begin
            o_res <= frsq_pkg::fp_round(r3_s, r3_n.e, r3_n.sig);
        end
        o_side <= r3_side;
    end

endmodule

// ===== design/frsq_fadd.sv =====
// Six-stage single-precision adder with a sideband that travels with each item.
module frsq_fadd (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    input  frsq_pkg::t_side      i_side,
    output logic                 o_valid,
    output logic [31:0]          o_res,
    output frsq_pkg::t_side      o_side
);

    logic [5:1] r_v;

    // stage 1: specials, unpack, order by magnitude
    logic               r1_spc;
    logic [31:0]        r1_sval;
    logic               r1_sa, r1_sb;
    logic [23:0]        r1_ma, r1_mb;
    logic signed [10:0] r1_ea;
    logic [10:0]        r1_d;
    frsq_pkg::t_side    r1_side;
    // stage 2: align
    logic               r2_spc;
    logic [31:0]        r2_sval;
    logic               r2_sa, r2_eff_sub;
    logic [53:0]        r2_xa, r2_xb;
    logic signed [10:0] r2_ea;
    frsq_pkg::t_side    r2_side;
    // stage 3: add or subtract
    logic               r3_spc;
    logic [31:0]        r3_sval;
    logic               r3_sa;
    logic [54:0]        r3_r;
    logic signed [10:0] r3_ea;
    frsq_pkg::t_side    r3_side;
    // stage 4: leading one
    logic               r4_spc;
    logic [31:0]        r4_sval;
    logic               r4_sa;
    logic [54:0]        r4_r;
    logic [5:0]         r4_p;
    logic signed [10:0] r4_ea;
    frsq_pkg::t_side    r4_side;
    // stage 5: normalize, denormalize
    logic               r5_spc;
    logic [31:0]        r5_sval;
    logic               r5_sa;
    logic               r5_ovf;
    frsq_pkg::t_norm    r5_n;
    frsq_pkg::t_side    r5_side;

    frsq_pkg::t_unp     n_ua, n_ub;
    logic               n_spc;
    logic [31:0]        n_sval;
    logic               n_swap;
    logic [53:0]        n_xb;
    logic [53:0]        n_msk;
    logic [5:0]         n_p;
    logic [54:0]        n_rn;
    logic [54:0]        n_lmsk;
    logic [5:0]         n_sh;
    logic signed [10:0] n_e;

    // special operands
    always_comb begin
        n_ua   = frsq_pkg::fp_unpack(i_a);
        n_ub   = frsq_pkg::fp_unpack(i_b);
        n_swap = (n_ub.e > n_ua.e) || (n_ub.e == n_ua.e && n_ub.m > n_ua.m);
        n_spc  = 1'b1;
        n_sval = frsq_pkg::F_QNAN;
        if (frsq_pkg::is_nan(i_a) || frsq_pkg::is_nan(i_b)) begin
            n_sval = frsq_pkg::F_QNAN;
        end else if (frsq_pkg::is_inf(i_a)) begin
            n_sval = (frsq_pkg::is_inf(i_b) && i_a[31] != i_b[31]) ? frsq_pkg::F_QNAN : i_a;
        end else if (frsq_pkg::is_inf(i_b)) begin
            n_sval = i_b;
        end else if (frsq_pkg::is_zero(i_a) && frsq_pkg::is_zero(i_b)) begin
            n_sval = {i_a[31] & i_b[31], 31'd0};
        end else if (frsq_pkg::is_zero(i_a)) begin
            n_sval = i_b;
        end else if (frsq_pkg::is_zero(i_b)) begin
            n_sval = i_a;
        end else begin
            n_spc = 1'b0;
        end
    end

    // alignment shift with sticky
    always_comb begin
        n_msk = ~(54'h3F_FFFF_FFFF_FFFF << r1_d[5:0]);
        if (r1_d >= 11'd54) begin
            n_xb = 54'd1;
        end else begin
            n_xb = ({r1_mb, 30'd0} >> r1_d[5:0]) | {53'd0, |({r1_mb, 30'd0} & n_msk)};
        end
    end

    // leading one position
    always_comb begin
        n_p = 6'd0;
        for (int i = 0; i < 55; i++) begin
            if (r3_r[i]) begin
                n_p = 6'(i);
            end
        end
    end

    // bring the leading one to bit 47
    always_comb begin
        n_sh   = 6'd0;
        n_lmsk = '0;
        if (r4_p > 6'd47) begin
            n_sh   = r4_p - 6'd47;
            n_lmsk = ~(55'h7F_FFFF_FFFF_FFFF << n_sh);
            n_rn   = (r4_r >> n_sh) | {54'd0, |(r4_r & n_lmsk)};
        end else begin
            n_rn = r4_r << (6'd47 - r4_p);
        end
        n_e = r4_ea + $signed({5'd0, r4_p}) - 11'sd53;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else begin
            r_v     <= {r_v[4:1], i_valid};
            o_valid <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_spc  <= n_spc;
        r1_sval <= n_sval;
        r1_side <= i_side;
        if (n_swap) begin
            r1_sa <= i_b[31];
            r1_sb <= i_a[31];
            r1_ma <= n_ub.m;
            r1_mb <= n_ua.m;
            r1_ea <= n_ub.e;
            r1_d  <= 11'(n_ub.e - n_ua.e);
        end else begin
            r1_sa <= i_a[31];
            r1_sb <= i_b[31];
            r1_ma <= n_ua.m;
            r1_mb <= n_ub.m;
            r1_ea <= n_ua.e;
            r1_d  <= 11'(n_ua.e - n_ub.e);
        end

        r2_spc     <= r1_spc;
        r2_sval    <= r1_sval;
        r2_sa      <= r1_sa;
        r2_eff_sub <= r1_sa != r1_sb;
        r2_xa      <= {r1_ma, 30'd0};
        r2_xb      <= n_xb;
        r2_ea      <= r1_ea;
        r2_side    <= r1_side;

        r3_spc  <= r2_spc;
        r3_sval <= r2_sval;
        r3_sa   <= r2_sa;
        r3_r    <= r2_eff_sub ? {1'b0, r2_xa} - {1'b0, r2_xb} : {1'b0, r2_xa} + {1'b0, r2_xb};
        r3_ea   <= r2_ea;
        r3_side <= r2_side;

        // exact cancellation gives +0
        r4_spc  <= r3_spc || (r3_r == 55'd0);
        r4_sval <= r3_spc ? r3_sval : 32'd0;
        r4_sa   <= r3_sa;
        r4_r    <= r3_r;
        r4_p    <= n_p;
        r4_ea   <= r3_ea;
        r4_side <= r3_side;

        r5_spc  <= r4_spc;
        r5_sval <= r4_sval;
        r5_sa   <= r4_sa;
        r5_ovf  <= n_e >= 11'sd255;
        r5_n    <= frsq_pkg::fp_denorm(n_e, n_rn[47:0]);
        r5_side <= r4_side;

        if (r5_spc) begin
            o_res <= r5_sval;
        end else if (r5_ovf) begin
            o_res <= {r5_sa, frsq_pkg::F_INF[30:0]};
        end else begin
            o_res <= frsq_pkg::fp_round(r5_sa, r5_n.e, r5_n.sig);
        end
        o_side <= r5_side;
    end

endmodule

// ===== design/fast_inverse_sqrt_newton3.sv =====
// Top level: reciprocal square root, bit-trick guess plus three Newton refinements.
// An accepted start passes the halving multiplier and then each refinement before the o_valid strobe.
// Throughput: one transaction per cycle; busy is always low since every unit is a
// fully pipelined multiplier (4 stages) or adder (6 stages) with no feedback.
// Each refinement is mul(h,y), mul(t,y), sub(1.5,t), mul(y,t).
// Reset (synchronous, active low) clears only the valid bits; data registers are free.
module fast_inverse_sqrt_newton3 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_operand_bits,
    output logic        o_valid,
    output logic [31:0] o_recip_root_bits
);

    localparam int N = frsq_pkg::NEWTON_STEPS;

    // Per-refinement boundary: valid, half operand, current estimate.
    logic            v_st [0:N];
    logic [31:0]     h_st [0:N];
    logic [31:0]     y_st [0:N];

    frsq_pkg::t_side side0_in, side0_out;
    logic [31:0]     h0;

    // No stalls anywhere in the pipe, a new transaction is taken every cycle.
    assign busy = 1'b0;

    // Bit-trick first guess: arithmetic shift keeps the sign bit.
    assign side0_in.h = 32'd0;
    assign side0_in.y = frsq_pkg::MAGIC_GUESS
                        - ({1'b0, i_operand_bits[31:1]} | (i_operand_bits & frsq_pkg::SIGN_BIT));

    // h = 0.5 * x, guess rides in the sideband
    frsq_fmul u_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_a     (frsq_pkg::F_HALF),
        .i_b     (i_operand_bits),
        .i_side  (side0_in),
        .o_valid (v_st[0]),
        .o_res   (h0),
        .o_side  (side0_out)
    );

    assign h_st[0] = h0;
    assign y_st[0] = side0_out.y;

    for (genvar k = 0; k < N; k++) begin : g_step
        frsq_pkg::t_side s_in, s_a, s_b, s_c, s_d;
        logic            v_a, v_b, v_c;
        logic [31:0]     t_a, t_b, t_c;

        assign s_in.h = h_st[k];
        assign s_in.y = y_st[k];

        // t = h * y
        frsq_fmul u_hy (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_st[k]),
            .i_a     (h_st[k]),
            .i_b     (y_st[k]),
            .i_side  (s_in),
            .o_valid (v_a),
            .o_res   (t_a),
            .o_side  (s_a)
        );

        // t = t * y
        frsq_fmul u_ty (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_a),
            .i_a     (t_a),
            .i_b     (s_a.y),
            .i_side  (s_a),
            .o_valid (v_b),
            .o_res   (t_b),
            .o_side  (s_b)
        );

        // t = 1.5 - t
        frsq_fadd u_sub (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_b),
            .i_a     (frsq_pkg::F_THREEHALF),
            .i_b     (t_b ^ frsq_pkg::SIGN_BIT),
            .i_side  (s_b),
            .o_valid (v_c),
            .o_res   (t_c),
            .o_side  (s_c)
        );

        // y = y * t
        frsq_fmul u_yt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_c),
            .i_a     (s_c.y),
            .i_b     (t_c),
            .i_side  (s_c),
            .o_valid (v_st[k+1]),
            .o_res   (y_st[k+1]),
            .o_side  (s_d)
        );

        assign h_st[k+1] = s_d.h;
    end

    assign o_valid           = v_st[N];
    assign o_recip_root_bits = y_st[N];

    // Every strobe traces back to a transaction exactly one latency earlier.
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, frsq_pkg::TOTAL_LAT))
        else $error("result strobe without matching transaction");

    // Each accepted transaction gives a strobe one latency later.
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(frsq_pkg::TOTAL_LAT) o_valid)
        else $error("transaction lost in pipeline");

    // Any NaN leaving the unit is the canonical quiet NaN.
    a_canon_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_recip_root_bits[30:23] == 8'hFF && o_recip_root_bits[22:0] != 23'd0)
        |-> o_recip_root_bits == frsq_pkg::F_QNAN)
        else $error("non-canonical NaN result");

    // A NaN operand propagates through every stage.
    a_nan_prop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operand_bits[30:23] == 8'hFF && i_operand_bits[22:0] != 23'd0)
        |-> ##(frsq_pkg::TOTAL_LAT) o_recip_root_bits == frsq_pkg::F_QNAN)
        else $error("NaN operand did not give quiet NaN");

endmodule
